FILE: rtl/bsm_pkg.sv
// Shared types and constants for the bank switch mapper.
`timescale 1ns / 1ps
`default_nettype none
package bsm_pkg;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam int PRG_MASK_W = 6;
  localparam int CHR_MASK_W = 8;
  localparam int BANK_W     = 8;
  localparam int NUM_BANKS  = 8;
  localparam int MAP_W      = 19;
  localparam int CNT_W      = 9;

  typedef enum logic [1:0] {
    OP_REG_WRITE = 2'd0,
    OP_TICK      = 2'd1,
    OP_PRG       = 2'd2,
    OP_CHR       = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] cpu_address;
    logic [12:0] ppu_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [MAP_W-1:0] mapped_address;
    logic             irq_line;
    logic             mirror_mode;
  } out_item_t;

  typedef struct packed {
    logic [PRG_MASK_W-1:0] prg_mask;
    logic [CHR_MASK_W-1:0] chr_mask;
  } cfg_t;

  // Bank view handed from the register file to the translator.
  typedef struct packed {
    logic                           prg_swap;
    logic                           chr_invert;
    logic [NUM_BANKS-1:0][BANK_W-1:0] banks;
  } map_view_t;

  // Interrupt and mirroring levels as they stand after the current word.
  typedef struct packed {
    logic irq_line;
    logic mirror_mode;
  } status_t;

  localparam logic [NUM_BANKS-1:0][BANK_W-1:0] BANK_RESET = {
    8'd1, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0
  };

  localparam logic [BANK_W-1:0] PRG_SECOND_LAST = 8'hFE;
  localparam logic [BANK_W-1:0] PRG_LAST        = 8'hFF;

endpackage
`default_nettype wire

FILE: rtl/bsm_apb.sv
// APB register block holding the bank size masks.
`timescale 1ns / 1ps
`default_nettype none
module bsm_apb (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bsm_pkg::APB_AW-1:0]  paddr,
  input  wire logic [bsm_pkg::APB_DW-1:0]  pwdata,
  output logic      [bsm_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  output bsm_pkg::cfg_t                    cfg
);
  import bsm_pkg::*;

  localparam logic REG_PRG_MASK = 1'b0;
  localparam logic REG_CHR_MASK = 1'b1;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prg_mask <= '1;
      cfg.chr_mask <= '1;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_PRG_MASK: cfg.prg_mask <= pwdata[PRG_MASK_W-1:0];
        REG_CHR_MASK: cfg.chr_mask <= pwdata[CHR_MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PRG_MASK: prdata = {{(APB_DW-PRG_MASK_W){1'b0}}, cfg.prg_mask};
      REG_CHR_MASK: prdata = {{(APB_DW-CHR_MASK_W){1'b0}}, cfg.chr_mask};
      default:      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/bsm_regs.sv
// Mapper register file and scanline interrupt counter.
`timescale 1ns / 1ps
`default_nettype none
module bsm_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire bsm_pkg::in_item_t item,
  output bsm_pkg::map_view_t     view,
  output bsm_pkg::status_t       status_next
);
  import bsm_pkg::*;

  // Decode key is {cpu_address[15:13], cpu_address[0]}.
  localparam logic [3:0] DEC_BANK_SELECT = 4'b1000;
  localparam logic [3:0] DEC_BANK_DATA   = 4'b1001;
  localparam logic [3:0] DEC_MIRROR      = 4'b1010;
  localparam logic [3:0] DEC_PRG_RAM     = 4'b1011;
  localparam logic [3:0] DEC_IRQ_LATCH   = 4'b1100;
  localparam logic [3:0] DEC_IRQ_RELOAD  = 4'b1101;
  localparam logic [3:0] DEC_IRQ_DISABLE = 4'b1110;
  localparam logic [3:0] DEC_IRQ_ENABLE  = 4'b1111;

  logic [BANK_W-1:0]                 bank_select, bank_select_next;
  logic [NUM_BANKS-1:0][BANK_W-1:0]  bank_regs, bank_regs_next;
  logic [CNT_W-1:0]                  irq_counter, irq_counter_next;
  logic [7:0]                        irq_reload_value, irq_reload_value_next;
  logic irq_enabled, irq_enabled_next;
  logic irq_asserted, irq_asserted_next;
  logic reload_on_enable, reload_on_enable_next;
  logic direct_load, direct_load_next;
  logic mirror_bit, mirror_bit_next;
  logic [3:0] dec;

  assign dec = {item.cpu_address[15:13], item.cpu_address[0]};

  always_comb begin
    bank_select_next      = bank_select;
    bank_regs_next        = bank_regs;
    irq_counter_next      = irq_counter;
    irq_reload_value_next = irq_reload_value;
    irq_enabled_next      = irq_enabled;
    irq_asserted_next     = irq_asserted;
    reload_on_enable_next = reload_on_enable;
    direct_load_next      = direct_load;
    mirror_bit_next       = mirror_bit;
    case (item.op)
      OP_REG_WRITE: begin
        unique case (dec)
          DEC_BANK_SELECT: bank_select_next = item.write_data;
          DEC_BANK_DATA:   bank_regs_next[bank_select[2:0]] = item.write_data;
          DEC_MIRROR:      mirror_bit_next = item.write_data[0];
          DEC_PRG_RAM: ;
          DEC_IRQ_LATCH: begin
            irq_reload_value_next = item.write_data;
            reload_on_enable_next = !direct_load;
            if (direct_load) begin
              irq_counter_next = {1'b0, item.write_data};
            end
          end
          DEC_IRQ_RELOAD:  irq_counter_next = {1'b0, irq_reload_value};
          DEC_IRQ_DISABLE: begin
            irq_enabled_next  = 1'b0;
            irq_asserted_next = 1'b0;
            direct_load_next  = 1'b1;
          end
          DEC_IRQ_ENABLE: begin
            irq_enabled_next = 1'b1;
            if (reload_on_enable) begin
              irq_counter_next = {1'b0, irq_reload_value};
            end
          end
          default: ;  // below the register window: drop
        endcase
      end
      OP_TICK: begin
        direct_load_next = 1'b0;
        // Stick at -1; raise the line on the step from zero.
        if (!irq_counter[CNT_W-1]) begin
          irq_counter_next = irq_counter - CNT_W'(1);
          if (irq_counter == '0 && irq_enabled) begin
            irq_asserted_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select      <= '0;
      bank_regs        <= BANK_RESET;
      irq_counter      <= '0;
      irq_reload_value <= '0;
      irq_enabled      <= 1'b0;
      irq_asserted     <= 1'b0;
      reload_on_enable <= 1'b0;
      direct_load      <= 1'b0;
      mirror_bit       <= 1'b0;
    end else if (fire) begin
      bank_select      <= bank_select_next;
      bank_regs        <= bank_regs_next;
      irq_counter      <= irq_counter_next;
      irq_reload_value <= irq_reload_value_next;
      irq_enabled      <= irq_enabled_next;
      irq_asserted     <= irq_asserted_next;
      reload_on_enable <= reload_on_enable_next;
      direct_load      <= direct_load_next;
      mirror_bit       <= mirror_bit_next;
    end
  end

  assign view.prg_swap   = bank_select[6];
  assign view.chr_invert = bank_select[7];
  assign view.banks      = bank_regs;

  assign status_next.irq_line    = irq_asserted_next;
  assign status_next.mirror_mode = mirror_bit_next;

endmodule
`default_nettype wire

FILE: rtl/bsm_xlate.sv
// Program and pattern address translation.
`timescale 1ns / 1ps
`default_nettype none
module bsm_xlate (
  input  wire bsm_pkg::in_item_t            item,
  input  wire bsm_pkg::map_view_t           view,
  input  wire bsm_pkg::cfg_t                cfg,
  output logic [bsm_pkg::MAP_W-1:0]         mapped_address
);
  import bsm_pkg::*;

  logic [BANK_W-1:0]     prg_bank;
  logic [PRG_MASK_W-1:0] prg_masked;
  logic [2:0]            slot;
  logic [2:0]            hi_idx;
  logic [BANK_W-1:0]     chr_bank;
  logic [CHR_MASK_W-1:0] chr_masked;

  always_comb begin
    case (item.cpu_address[14:13])
      2'd0:    prg_bank = view.prg_swap ? PRG_SECOND_LAST : view.banks[6];
      2'd1:    prg_bank = view.banks[7];
      2'd2:    prg_bank = view.prg_swap ? view.banks[6] : PRG_SECOND_LAST;
      default: prg_bank = PRG_LAST;
    endcase
    prg_masked = prg_bank[PRG_MASK_W-1:0] & cfg.prg_mask;
  end

  // Swap the 2K and 1K halves when inversion is set.
  assign slot   = item.ppu_address[12:10] ^ {view.chr_invert, 2'b00};
  assign hi_idx = slot - 3'd2;

  always_comb begin
    if (!slot[2]) begin
      chr_bank = {view.banks[{2'b00, slot[1]}][BANK_W-1:1], slot[0]};
    end else begin
      chr_bank = view.banks[hi_idx];
    end
    chr_masked = chr_bank & cfg.chr_mask;
  end

  always_comb begin
    case (item.op)
      OP_PRG: begin
        if (item.cpu_address[15]) begin
          mapped_address = {prg_masked, item.cpu_address[12:0]};
        end else begin
          mapped_address = '0;
        end
      end
      OP_CHR:  mapped_address = {1'b0, chr_masked, item.ppu_address[9:0]};
      default: mapped_address = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/bank_switch_mapper_with_scanline_irq_core.sv
// Top level of the bank switch mapper with scanline interrupt counter.
//
//   channel  direction  handshake                  word
//   item     in         item_valid / item_ready    bsm_pkg::in_item_t
//   result   out        result_valid / result_ready bsm_pkg::out_item_t
//   apb      in         psel / penable / pready    mask registers at 0x0, 0x4
//
// One word per cycle sustained while result_ready stays high; each word passes through
// the input register and then the result register.
// Mapper state updates when a word moves from the input register to the result
// register. Reset is synchronous and restores the power-on bank layout.
// A stalled result holds; the input register still takes one more word.
`timescale 1ns / 1ps
`default_nettype none
module bank_switch_mapper_with_scanline_irq_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_ready,
  input  wire bsm_pkg::in_item_t          item,
  output logic                            result_valid,
  input  wire logic                       result_ready,
  output bsm_pkg::out_item_t              result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bsm_pkg::APB_AW-1:0] paddr,
  input  wire logic [bsm_pkg::APB_DW-1:0] pwdata,
  output logic      [bsm_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import bsm_pkg::*;

  logic             stage_valid;
  in_item_t         stage_item;
  logic             advance;
  cfg_t             cfg;
  map_view_t        view;
  status_t          status_next;
  logic [MAP_W-1:0] mapped_address;

  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  bsm_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsm_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .item        (stage_item),
    .view        (view),
    .status_next (status_next)
  );

  bsm_xlate u_xlate (
    .item           (stage_item),
    .view           (view),
    .cfg            (cfg),
    .mapped_address (mapped_address)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.mapped_address <= mapped_address;
      result.irq_line       <= status_next.irq_line;
      result.mirror_mode    <= status_next.mirror_mode;
    end
  end

`ifndef ASSERT_OFF
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_item))
    else $error("input register lost or changed a waiting word");

  a_no_map_on_ctrl: assert property (@(posedge clk) disable iff (rst)
    advance && (stage_item.op == OP_REG_WRITE || stage_item.op == OP_TICK)
    |=> result.mapped_address == '0)
    else $error("nonzero mapped address for a register write or tick");

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(stage_valid))
    else $error("result appeared without a word in the input register");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/bsm_tb_pkg.sv
// Scoreboard for the bank switch mapper: mapping predictor and expected result store.
`timescale 1ns / 1ps
package bsm_tb_pkg;
  import bsm_pkg::*;

  // Register decode on cpu_address bits 15:13 and 0.
  localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
  localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
  localparam logic [15:0] REG_MIRROR      = 16'hA000;
  localparam logic [15:0] REG_PROTECT     = 16'hA001;
  localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
  localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
  localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;
  localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;
  localparam logic [15:0] ROM_BASE        = 16'h8000;

  localparam logic [APB_AW-1:0] CFG_PRG_MASK = 3'h0;
  localparam logic [APB_AW-1:0] CFG_CHR_MASK = 3'h4;

  localparam int PRG_SWITCH_REG = 6;
  localparam int PRG_MIDDLE_REG = 7;

  class bank_map_scoreboard;
    logic [PRG_MASK_W-1:0] prg_mask;
    logic [CHR_MASK_W-1:0] chr_mask;
    logic [7:0]            bank_sel;
    logic [BANK_W-1:0]     banks [NUM_BANKS];
    logic [CNT_W-1:0]      irq_count;
    logic [7:0]            irq_latch;
    bit                    irq_enabled;
    bit                    irq_pending;
    bit                    latch_armed;
    bit                    direct_load;
    bit                    mirror_h;
    out_item_t             mapped_results_q[$];
    int                    errors;

    function new();
      prg_mask    = '1;
      chr_mask    = '1;
      bank_sel    = '0;
      for (int i = 0; i < NUM_BANKS; i++) banks[i] = BANK_RESET[i];
      irq_count   = '0;
      irq_latch   = '0;
      irq_enabled = 1'b0;
      irq_pending = 1'b0;
      latch_armed = 1'b0;
      direct_load = 1'b0;
      mirror_h    = 1'b0;
      errors      = 0;
    endfunction

    function void set_mask(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
      if (addr == CFG_PRG_MASK) prg_mask = data[PRG_MASK_W-1:0];
      else if (addr == CFG_CHR_MASK) chr_mask = data[CHR_MASK_W-1:0];
    endfunction

    function int pending();
      return mapped_results_q.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // Advance the mapper state by one input word and queue the result it yields.
    function void note_word(in_item_t w);
      logic [15:0]       addr;
      logic [7:0]        d;
      logic [BANK_W-1:0] bank;
      logic [2:0]        slot;
      out_item_t         res;
      addr = w.cpu_address;
      d    = w.write_data;
      res  = '0;
      case (w.op)
        OP_REG_WRITE: begin
          // addresses below the ROM never match a decode entry
          case (addr & REG_DECODE_MASK)
            REG_BANK_SELECT: bank_sel = d;
            REG_BANK_DATA:   banks[bank_sel[2:0]] = d;
            REG_MIRROR:      mirror_h = d[0];
            REG_IRQ_LATCH: begin
              irq_latch   = d;
              latch_armed = 1'b1;
              if (direct_load) begin
                irq_count   = {1'b0, d};
                latch_armed = 1'b0;
              end
            end
            REG_IRQ_RELOAD:  irq_count = {1'b0, irq_latch};
            REG_IRQ_DISABLE: begin
              irq_enabled = 1'b0;
              irq_pending = 1'b0;
              direct_load = 1'b1;
            end
            REG_IRQ_ENABLE: begin
              irq_enabled = 1'b1;
              if (latch_armed) irq_count = {1'b0, irq_latch};
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          direct_load = 1'b0;
          // hold at -1 once the sign bit is set
          if (!irq_count[CNT_W-1]) begin
            irq_count = irq_count - 1'b1;
            if (irq_count[CNT_W-1] && irq_enabled) irq_pending = 1'b1;
          end
        end
        OP_PRG: begin
          if (addr >= ROM_BASE) begin
            case (addr[14:13])
              2'd0:    bank = bank_sel[6] ? PRG_SECOND_LAST : banks[PRG_SWITCH_REG];
              2'd1:    bank = banks[PRG_MIDDLE_REG];
              2'd2:    bank = bank_sel[6] ? banks[PRG_SWITCH_REG] : PRG_SECOND_LAST;
              default: bank = PRG_LAST;
            endcase
            res.mapped_address = {bank[5:0] & prg_mask, addr[12:0]};
          end
        end
        default: begin
          slot = w.ppu_address[12:10] ^ {bank_sel[7], 2'b00};
          // 2K windows pair an even bank with its odd neighbor
          if (!slot[2]) bank = {banks[slot[1]][BANK_W-1:1], slot[0]};
          else bank = banks[slot - 3'd2];
          res.mapped_address = {1'b0, bank & chr_mask, w.ppu_address[9:0]};
        end
      endcase
      res.irq_line    = irq_pending;
      res.mirror_mode = mirror_h;
      mapped_results_q.push_back(res);
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      if (mapped_results_q.size() == 0) begin
        report($sformatf("result word with nothing expected: mapped_address %h irq %b mirror %b",
                         got.mapped_address, got.irq_line, got.mirror_mode));
        return;
      end
      want = mapped_results_q.pop_front();
      if (got.mapped_address !== want.mapped_address || got.irq_line !== want.irq_line ||
          got.mirror_mode !== want.mirror_mode)
        report($sformatf("mismatch exp/act: mapped_address %h/%h irq %b/%b mirror %b/%b",
                         want.mapped_address, got.mapped_address, want.irq_line,
                         got.irq_line, want.mirror_mode, got.mirror_mode));
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_top.sv
// Top-level testbench for the bank switch mapper with scanline interrupt counter.
`timescale 1ns / 1ps
module tb_top;
  import bsm_pkg::*;
  import bsm_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_WORDS    = 360;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_SPARSE} stall_t;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  in_item_t            item         = '0;
  logic                item_ready;
  logic                result_valid;
  logic                result_ready = 1'b0;
  out_item_t           result;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [APB_AW-1:0]   paddr        = '0;
  logic [APB_DW-1:0]   pwdata       = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  bank_map_scoreboard  sb;
  int                  burst_left;
  int                  words_sent;
  int                  idle_cycles;
  bit                  hold_req;
  stall_t              stall_mode;

  bank_switch_mapper_with_scanline_irq_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Check results before noting inputs so a stray result cannot match a fresh word.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_word(result);
      if (item_valid && item_ready) sb.note_word(item);
      if ((result_valid && result_ready) || (item_valid && item_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : result_stalls
    int span;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (span == 0) begin
        stall_mode = stall_t'($urandom_range(0, 3));
        span = $urandom_range(20, 200);
      end
      span--;
      case (stall_mode)
        STALL_NONE:     result_ready <= 1'b1;
        STALL_COIN:     result_ready <= 1'($urandom_range(0, 1));
        STALL_PERIODIC: result_ready <= (span % 4) != 0;
        default:        result_ready <= $urandom_range(0, 7) != 0;
      endcase
    end
  end

  task automatic send_word(input in_item_t w);
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end
  endtask

  // Drop valid and wait until every expected word is back.
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_mask(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t word_of(op_t op, logic [15:0] cpu, logic [12:0] ppu,
                                       logic [7:0] d);
    in_item_t w;
    w.op          = op;
    w.cpu_address = cpu;
    w.ppu_address = ppu;
    w.write_data  = d;
    return w;
  endfunction

  function automatic in_item_t random_word(input bit rom_only);
    in_item_t w;
    w.op          = op_t'($urandom_range(0, 3));
    w.cpu_address = 16'($urandom);
    w.ppu_address = 13'($urandom);
    w.write_data  = 8'($urandom);
    if (rom_only) w.cpu_address[15] = 1'b1;
    return w;
  endfunction

  // Register write with the undecoded address bits scrambled.
  function automatic in_item_t reg_word(input logic [15:0] reg_addr, input logic [7:0] d);
    return word_of(OP_REG_WRITE, reg_addr | (16'($urandom) & ~REG_DECODE_MASK),
                   13'($urandom), d);
  endfunction

  function automatic in_item_t translate_word();
    in_item_t w;
    w = random_word($urandom_range(0, 7) != 0);
    w.op = op_t'({1'b1, 1'($urandom)});
    return w;
  endfunction

  task automatic run_directed();
    send_word(word_of(OP_PRG, 16'h0000, 13'h0000, 8'h00));
    send_word(word_of(OP_PRG, 16'h7FFF, 13'h1FFF, 8'hFF));
    send_word(word_of(OP_PRG, 16'h8000, 13'h0000, 8'h00));
    send_word(word_of(OP_PRG, 16'hC000, 13'h0000, 8'h00));
    send_word(word_of(OP_PRG, 16'hFFFF, 13'h0000, 8'h00));
    send_word(word_of(OP_CHR, 16'h0000, 13'h0000, 8'h00));
    send_word(word_of(OP_CHR, 16'h0000, 13'h1FFF, 8'h00));
    // write below the ROM must change nothing
    send_word(word_of(OP_REG_WRITE, 16'h6000, 13'h0000, 8'hFF));
    // swap program windows, invert pattern halves, select bank 6
    send_word(word_of(OP_REG_WRITE, REG_BANK_SELECT, 13'h0000, 8'hC6));
    send_word(word_of(OP_REG_WRITE, REG_BANK_DATA, 13'h0000, 8'hFF));
    send_word(word_of(OP_PRG, 16'h8123, 13'h0000, 8'h00));
    send_word(word_of(OP_CHR, 16'h0000, 13'h0400, 8'h00));
    send_word(word_of(OP_REG_WRITE, REG_MIRROR, 13'h0000, 8'h01));
    send_word(word_of(OP_REG_WRITE, REG_PROTECT, 13'h0000, 8'hFE));
    // count 1 -> 0 -> -1 with interrupts on, then stick at -1
    send_word(word_of(OP_REG_WRITE, REG_IRQ_LATCH, 13'h0000, 8'h01));
    send_word(word_of(OP_REG_WRITE, REG_IRQ_RELOAD, 13'h0000, 8'h00));
    send_word(word_of(OP_REG_WRITE, REG_IRQ_ENABLE, 13'h0000, 8'h00));
    send_word(word_of(OP_TICK, 16'h0000, 13'h0000, 8'h00));
    send_word(word_of(OP_TICK, 16'h0000, 13'h0000, 8'h00));
    send_word(word_of(OP_TICK, 16'h0000, 13'h0000, 8'h00));
    // disable arms direct load; reach -1 while disabled, enable must not raise the line
    send_word(word_of(OP_REG_WRITE, REG_IRQ_DISABLE, 13'h0000, 8'h00));
    send_word(word_of(OP_REG_WRITE, REG_IRQ_LATCH, 13'h0000, 8'h00));
    send_word(word_of(OP_TICK, 16'h0000, 13'h0000, 8'h00));
    send_word(word_of(OP_REG_WRITE, REG_IRQ_ENABLE, 13'h0000, 8'h00));
  endtask

  task automatic run_random(input int n, input bit with_hold, input bit with_pause);
    int         start;
    logic [7:0] d;
    in_item_t   w;
    start = words_sent;
    while (words_sent - start < n) begin
      if (with_hold && words_sent - start >= 40) begin
        hold_req  = 1'b1;
        with_hold = 1'b0;
      end
      if (with_pause && words_sent - start >= 200) begin
        wait_idle();
        with_pause = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          send_word(reg_word(REG_BANK_SELECT, 8'($urandom)));
          send_word(reg_word(REG_BANK_DATA, 8'($urandom)));
          repeat ($urandom_range(1, 4)) send_word(translate_word());
        end
        3, 4: begin
          d = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
          if ($urandom_range(0, 3) == 0) send_word(reg_word(REG_IRQ_DISABLE, 8'($urandom)));
          send_word(reg_word(REG_IRQ_LATCH, d));
          if ($urandom_range(0, 1)) send_word(reg_word(REG_IRQ_RELOAD, 8'($urandom)));
          send_word(reg_word($urandom_range(0, 4) != 0 ? REG_IRQ_ENABLE : REG_IRQ_DISABLE,
                             8'($urandom)));
          repeat ($urandom_range(0, 10)) begin
            if ($urandom_range(0, 3) != 0) begin
              w = random_word(1'b0);
              w.op = OP_TICK;
            end else begin
              w = translate_word();
            end
            send_word(w);
          end
        end
        5, 6, 7, 8: send_word(random_word(1'b1));
        default:    send_word(random_word(1'b0));
      endcase
    end
  endtask

  initial begin
    sb          = new();
    burst_left  = 0;
    words_sent  = 0;
    idle_cycles = 0;
    hold_req    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_write(CFG_PRG_MASK, 32'h3F);
    apb_write(CFG_CHR_MASK, 32'hFF);
    run_directed();
    wait_idle();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          apb_write(CFG_PRG_MASK, 32'($urandom_range(1, 62)));
          apb_write(CFG_CHR_MASK, 32'($urandom_range(1, 254)));
        end
        1: begin
          apb_write(CFG_PRG_MASK, 32'h00);
          apb_write(CFG_CHR_MASK, 32'h00);
        end
        2: begin
          apb_write(CFG_PRG_MASK, 32'($urandom_range(0, 63)));
          apb_write(CFG_CHR_MASK, 32'hFF);
        end
        default: begin
          apb_write(CFG_PRG_MASK, 32'h3F);
          apb_write(CFG_CHR_MASK, 32'($urandom_range(0, 255)));
        end
      endcase
      run_random(PHASE_WORDS, p == 0, p == 1);
      wait_idle();
    end
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/bsm_pkg.sv
rtl/bsm_apb.sv
rtl/bsm_regs.sv
rtl/bsm_xlate.sv
rtl/bank_switch_mapper_with_scanline_irq_core.sv
tb/sv/bsm_tb_pkg.sv
tb/sv/tb_top.sv
